// File: sv/totient_and_modular_power_unit_assert.svh
// Assertion macros for the totient and modular power unit.
`ifndef TOTIENT_AND_MODULAR_POWER_UNIT_ASSERT_SVH
`define TOTIENT_AND_MODULAR_POWER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TMP_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define TMP_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define TMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/tmp_pkg.sv
// Shared types and constants for the totient and modular power unit.
`timescale 1ns / 1ps
package tmp_pkg;
  localparam int DEF_WIDTH = 16;
  localparam int VALUE_W = 16;
  localparam logic [1:0] CMD_TOT = 2'd0;
  localparam logic [1:0] CMD_FERMAT = 2'd1;
  localparam logic [1:0] CMD_EULER = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_COPRIME = 2'd1;
  localparam logic [1:0] ST_ZERO_MOD = 2'd2;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_GCD_NI, OP_GCD_NM, OP_GCD_STEP, OP_TOT_NEXT,
    OP_PW_INIT, OP_MUL_ACC, OP_MUL_SQ, OP_MOD_STEP, OP_MOD_START_RED,
    OP_SHIFT_E, OP_DONE, OP_TOT_M
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic gcd_done;   // remainder of current gcd is zero
    logic gcd_one;    // gcd result is one
    logic tot_end;    // loop index reached the totient operand
    logic mod_done;   // shift-subtract reduction finished
    logic e_zero;
    logic e_lsb;
    logic m_zero;
    logic [1:0] cmd;
  } stat_t;
endpackage

// File: sv/tmp_datapath.sv
// Datapath: operand registers, Euclid remainder unit, shift-subtract modulo reducer.
`timescale 1ns / 1ps
module tmp_datapath #(
  parameter int WIDTH = tmp_pkg::DEF_WIDTH
) (
  input  logic clk,
  input  tmp_pkg::cmd_t cmd_i,
  input  logic [1:0] in_command,
  input  logic [15:0] in_number,
  input  logic [15:0] in_modulus,
  output tmp_pkg::stat_t stat_o,
  output logic [15:0] res_value
);
  import tmp_pkg::*;
  localparam int CW = $clog2(2 * WIDTH + 1);

  logic [1:0] cmd_r;
  logic [WIDTH-1:0] n_r, m_r, tn_r, i_r, cnt_r, gx_r, gy_r, acc_r, b_r, e_r;
  logic [2*WIDTH-1:0] rem_r, prod_r;
  logic [2*WIDTH-1:0] dv_r;
  logic [CW-1:0] sh_r;
  logic red_acc_r;   // reduction target: acc or base

  // gcd remainder: gx mod gy by one compare-subtract per step is too slow;
  // use shift-subtract reducer shared with power path
  logic [2*WIDTH-1:0] rem_sub;
  assign rem_sub = rem_r - dv_r;

  always_ff @(posedge clk) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        cmd_r <= in_command;
        n_r <= WIDTH'(in_number);
        m_r <= WIDTH'(in_modulus);
        tn_r <= WIDTH'(in_number);
        i_r <= WIDTH'(1);
        cnt_r <= '0;
      end
      // restart the totient loop on the modulus
      OP_TOT_M: begin
        tn_r <= m_r;
        i_r <= WIDTH'(1);
        cnt_r <= '0;
      end
      OP_GCD_NI: begin
        gx_r <= tn_r; gy_r <= i_r;
        rem_r <= (2*WIDTH)'(tn_r);
        dv_r <= (2*WIDTH)'(i_r) << WIDTH; sh_r <= CW'(WIDTH + 1);
      end
      OP_GCD_NM: begin
        gx_r <= n_r; gy_r <= m_r;
        rem_r <= (2*WIDTH)'(n_r);
        dv_r <= (2*WIDTH)'(m_r) << WIDTH; sh_r <= CW'(WIDTH + 1);
      end
      OP_MOD_STEP: begin
        if (rem_r >= dv_r) rem_r <= rem_sub;
        dv_r <= dv_r >> 1;
        sh_r <= sh_r - CW'(1);
      end
      OP_GCD_STEP: begin
        // rem_r now holds gx mod gy
        gx_r <= gy_r; gy_r <= rem_r[WIDTH-1:0];
        rem_r <= (2*WIDTH)'(gy_r);
        dv_r <= (2*WIDTH)'(rem_r[WIDTH-1:0]) << WIDTH; sh_r <= CW'(WIDTH + 1);
      end
      OP_TOT_NEXT: begin
        if (gx_r == WIDTH'(1)) cnt_r <= cnt_r + WIDTH'(1);
        i_r <= i_r + WIDTH'(1);
      end
      OP_PW_INIT: begin
        // exponent: m-1 for Fermat, count for Euler; base reduce starts
        e_r <= (cmd_r == CMD_FERMAT) ? m_r - WIDTH'(1) : cnt_r;
        acc_r <= (m_r == WIDTH'(1)) ? '0 : WIDTH'(1);
        b_r <= n_r;
        red_acc_r <= 1'b0;
        rem_r <= (2*WIDTH)'(n_r);
        dv_r <= (2*WIDTH)'(m_r) << WIDTH; sh_r <= CW'(WIDTH + 1);
      end
      OP_MUL_ACC: begin
        prod_r <= (2*WIDTH)'(acc_r) * (2*WIDTH)'(b_r);
        red_acc_r <= 1'b1;
      end
      OP_MUL_SQ: begin
        prod_r <= (2*WIDTH)'(b_r) * (2*WIDTH)'(b_r);
        red_acc_r <= 1'b0;
      end
      OP_MOD_START_RED: begin
        rem_r <= prod_r;
        dv_r <= (2*WIDTH)'(m_r) << WIDTH; sh_r <= CW'(WIDTH + 1);
      end
      OP_SHIFT_E: begin
        if (red_acc_r) acc_r <= rem_r[WIDTH-1:0];
        else b_r <= rem_r[WIDTH-1:0];
      end
      OP_DONE: e_r <= e_r >> 1;
      default: ;
    endcase
  end

  // the remainder result of a reduction is stored by the controller via OP_SHIFT_E
  assign stat_o.gcd_done = (gy_r == '0);
  assign stat_o.gcd_one = (gx_r == WIDTH'(1));
  assign stat_o.tot_end = (i_r >= tn_r);
  assign stat_o.mod_done = (sh_r == '0);
  assign stat_o.e_zero = (e_r == '0);
  assign stat_o.e_lsb = e_r[0];
  assign stat_o.m_zero = (m_r == '0);
  assign stat_o.cmd = cmd_r;

  logic [15:0] v16;
  always_comb begin
    v16 = '0;
    if (cmd_r == CMD_TOT) v16 = 16'(cnt_r);
    else v16 = 16'(acc_r);
  end
  assign res_value = v16;
endmodule

// File: sv/tmp_ctrl.sv
// Controller: sequences gcd, totient loop and square-and-multiply.
`timescale 1ns / 1ps
module tmp_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  tmp_pkg::stat_t stat_i,
  output tmp_pkg::cmd_t cmd_o,
  output logic [1:0] res_status,
  output logic res_zero
);
  import tmp_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_TG = 4'd2, S_TGR = 4'd3,
    S_TNXT = 4'd4, S_CG = 4'd5, S_CGR = 4'd6, S_PINIT = 4'd7, S_BRED = 4'd8,
    S_LOOP = 4'd9, S_RED = 4'd10, S_SQ = 4'd11, S_SQR = 4'd12, S_OUT = 4'd13,
    S_TOTI = 4'd14;

  logic [3:0] st_r, st_nxt;
  logic [1:0] sts_r, sts_nxt;
  logic z_r, z_nxt;
  logic euler_r, euler_nxt;   // computing totient of modulus
  logic sq_r, sq_nxt;         // reduction belongs to square step
  logic shift_pend_r, shift_pend_nxt;

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign res_status = sts_r;
  assign res_zero = z_r;

  always_comb begin
    st_nxt = st_r; sts_nxt = sts_r; z_nxt = z_r; euler_nxt = euler_r; sq_nxt = sq_r;
    cmd_o.op = OP_NONE;
    unique case (st_r)
      S_IDLE: if (in_valid) begin cmd_o.op = OP_LOAD; st_nxt = S_DISP; end
      S_DISP: begin
        sts_nxt = ST_OK; z_nxt = 1'b0; euler_nxt = 1'b0;
        priority if (stat_i.cmd == CMD_TOT) st_nxt = S_TOTI;
        else if (stat_i.cmd == CMD_UNUSED) begin z_nxt = 1'b1; st_nxt = S_OUT; end
        else if (stat_i.m_zero) begin
          sts_nxt = ST_ZERO_MOD; z_nxt = 1'b1; st_nxt = S_OUT;
        end else begin cmd_o.op = OP_GCD_NM; st_nxt = S_CGR; end
      end
      // totient loop over i
      S_TOTI: begin
        if (stat_i.tot_end) st_nxt = euler_r ? S_PINIT : S_OUT;
        else begin cmd_o.op = OP_GCD_NI; st_nxt = S_TGR; end
      end
      S_TGR: begin
        if (stat_i.gcd_done) st_nxt = S_TNXT;
        else if (stat_i.mod_done) cmd_o.op = OP_GCD_STEP;
        else cmd_o.op = OP_MOD_STEP;
      end
      S_TNXT: begin cmd_o.op = OP_TOT_NEXT; st_nxt = S_TOTI; end
      // coprimality of number and modulus
      S_CGR: begin
        if (stat_i.gcd_done) begin
          if (!stat_i.gcd_one) begin
            sts_nxt = ST_NOT_COPRIME; z_nxt = 1'b1; st_nxt = S_OUT;
          end else if (stat_i.cmd == CMD_EULER) begin
            euler_nxt = 1'b1; st_nxt = S_CG;
          end else st_nxt = S_PINIT;
        end else if (stat_i.mod_done) cmd_o.op = OP_GCD_STEP;
        else cmd_o.op = OP_MOD_STEP;
      end
      S_CG: begin cmd_o.op = OP_TOT_M; st_nxt = S_TG; end
      S_TG: st_nxt = S_TOTI;
      S_PINIT: begin cmd_o.op = OP_PW_INIT; sq_nxt = 1'b1; st_nxt = S_BRED; end
      // reduce base or product
      S_BRED: begin
        if (stat_i.mod_done) begin
          cmd_o.op = OP_SHIFT_E;
          st_nxt = sq_r ? S_SQR : S_SQ;
        end else cmd_o.op = OP_MOD_STEP;
      end
      S_SQR: begin
        // after a square: shift exponent unless just base reduce of init
        st_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (stat_i.e_zero) st_nxt = S_OUT;
        else if (stat_i.e_lsb) begin cmd_o.op = OP_MUL_ACC; sq_nxt = 1'b0; st_nxt = S_RED; end
        else st_nxt = S_SQ;
      end
      S_SQ: begin cmd_o.op = OP_MUL_SQ; sq_nxt = 1'b1; st_nxt = S_RED; end
      S_RED: begin cmd_o.op = OP_MOD_START_RED; st_nxt = S_BRED; end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    // shift exponent after each square reduction completes
    if (st_r == S_SQR && sq_r && sts_r == ST_OK && shift_pend_r) cmd_o.op = OP_DONE;
  end

  always_comb begin
    shift_pend_nxt = shift_pend_r;
    if (st_r == S_PINIT) shift_pend_nxt = 1'b0;
    else if (st_r == S_SQ) shift_pend_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; sts_r <= ST_OK; z_r <= 1'b0; euler_r <= 1'b0;
      sq_r <= 1'b0; shift_pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt; sts_r <= sts_nxt; z_r <= z_nxt; euler_r <= euler_nxt;
      sq_r <= sq_nxt; shift_pend_r <= shift_pend_nxt;
    end
  end
endmodule

// File: sv/totient_and_modular_power_unit.sv
// Top level of the totient and modular power unit.
// Channel | ports                                   | dir
// input   | in_valid in_ready in_command/number/mod | in
// result  | out_valid out_ready out_value out_status| out
// One item at a time; in_ready is low from the input transfer until the result transfer.
// Totient of n: for each i from 1 below n, a gcd of n and i by Euclid rounds, each a
// shift-subtract reduction; i is counted when the gcd is one.
// Powers: a gcd check, a base reduction, then per exponent bit a square and, for a set
// bit, a multiply, each reduced by shift-subtract; plus the totient loop over the modulus for Euler.
// Reset is synchronous; the result holds in its register until transferred.
`timescale 1ns / 1ps
`include "totient_and_modular_power_unit_assert.svh"
module totient_and_modular_power_unit #(
  parameter int WIDTH = tmp_pkg::DEF_WIDTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_command,
  input  logic [15:0] in_number,
  input  logic [15:0] in_modulus,
  output logic out_valid,
  input  logic out_ready,
  output logic [15:0] out_value,
  output logic [1:0] out_status
);
  import tmp_pkg::*;
  cmd_t cmd;
  stat_t stat;
  logic [15:0] v;
  logic z;

  tmp_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat_i(stat), .cmd_o(cmd), .res_status(out_status), .res_zero(z));
  tmp_datapath #(.WIDTH(WIDTH)) u_dp (.clk, .cmd_i(cmd), .in_command, .in_number,
    .in_modulus, .stat_o(stat), .res_value(v));

  assign out_value = z ? 16'd0 : v;

  `TMP_ASSERT_IMPL(a_excl, clk, rst_n, !(in_ready && out_valid), "ready while result pending")
  `TMP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  `TMP_ASSERT_IMPL(a_zero, clk, rst_n, !(out_valid && |out_status && |out_value), "err value")
endmodule
